@@ rtl/tmq_pkg.sv @@
// Shared types and codes of the timed message queue.
`default_nettype none

package tmq_pkg;

  // Command codes carried on in_tuser.
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_LIST  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // Result kinds carried on out_tuser.
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_ENTRY  = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  // Register indexes of the configuration port (byte address = 4 * index).
  localparam logic [1:0] REG_X_POS   = 2'd0;
  localparam logic [1:0] REG_START_Y = 2'd1;
  localparam logic [1:0] REG_Y_STEP  = 2'd2;
  localparam logic [1:0] REG_DEPTH_Z = 2'd3;

  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] ticks;
    logic [31:0] fore;
    logic [31:0] back;
    logic [31:0] shade;
  } slot_t;

  typedef struct packed {
    logic  alive;
    slot_t slot;
  } entry_t;

  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_PUSH   = 3'd1,
    OP_ROTATE = 3'd2,
    OP_MARK   = 3'd3,
    OP_SORT   = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     phase;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/tmq_cell.sv @@
// One slot of the message chain: push, rotate, age and odd-even compaction.
`default_nettype none

module tmq_cell #(
  parameter bit ODD      = 1'b0,
  parameter bit LOW_END  = 1'b0,
  parameter bit HIGH_END = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tmq_pkg::cell_ctrl_t ctrl,
  input  logic                occ,
  input  tmq_pkg::entry_t     dn_in,
  input  tmq_pkg::entry_t     up_in,
  output tmq_pkg::entry_t     q
);
  import tmq_pkg::*;

  slot_t  slot_r;
  logic   alive_r;
  entry_t cur;
  entry_t ent_nxt;
  logic   lower_role;
  logic   upper_role;

  assign cur = '{alive: alive_r, slot: slot_r};
  assign q   = cur;

  always_comb begin
    lower_role = (ctrl.phase == ODD) && !HIGH_END;
    upper_role = (ctrl.phase != ODD) && !LOW_END;
    ent_nxt    = cur;
    case (ctrl.op)
      OP_PUSH:   ent_nxt = dn_in;
      OP_ROTATE: ent_nxt = up_in;
      OP_MARK: begin
        ent_nxt.slot.ticks = cur.slot.ticks - 16'd1;
        ent_nxt.alive      = occ && (cur.slot.ticks != 16'd1);
      end
      OP_SORT: begin
        // swap a dead entry with a live neighbor above it
        if (lower_role && !cur.alive && up_in.alive) begin
          ent_nxt = up_in;
        end else if (upper_role && cur.alive && !dn_in.alive) begin
          ent_nxt = dn_in;
        end
      end
      default: ent_nxt = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    slot_r <= ent_nxt.slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= 1'b0;
    end else begin
      alive_r <= ent_nxt.alive;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tmq_cfg.sv @@
// APB register file holding the screen placement settings.
`default_nettype none

module tmq_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic [15:0] x_position,
  output logic [15:0] start_y,
  output logic [15:0] y_step,
  output logic [15:0] depth_z
);
  import tmq_pkg::*;

  logic [15:0] x_pos_r, start_y_r, y_step_r, depth_z_r;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign x_position = x_pos_r;
  assign start_y    = start_y_r;
  assign y_step     = y_step_r;
  assign depth_z    = depth_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_pos_r   <= '0;
      start_y_r <= '0;
      y_step_r  <= '0;
      depth_z_r <= '0;
    end else if (wr_en) begin
      unique case (cfg_paddr[3:2])
        REG_X_POS:   x_pos_r   <= cfg_pwdata[15:0];
        REG_START_Y: start_y_r <= cfg_pwdata[15:0];
        REG_Y_STEP:  y_step_r  <= cfg_pwdata[15:0];
        REG_DEPTH_Z: depth_z_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_X_POS:   cfg_prdata = {16'd0, x_pos_r};
      REG_START_Y: cfg_prdata = {16'd0, start_y_r};
      REG_Y_STEP:  cfg_prdata = {16'd0, y_step_r};
      REG_DEPTH_Z: cfg_prdata = {16'd0, depth_z_r};
      default:     cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/timed_message_queue.sv @@
// Top level of the timed message queue: command sequencer, slot chain, result register.
//
//   port group | dir | contents
//   in_*       | in  | command transactions (tuser: command; tdata: message fields)
//   out_*      | out | result transactions (tuser: kind; tlast: end of run)
//   cfg_*      | i/o | APB register access, four 16-bit settings
//
// Add, clear and list of an empty queue go from idle to the status state; tick marks
// the chain, then runs the odd-even compaction over it (one phase per cycle) before the
// count and status states. List sends one entry per cycle while out_tready allows, as
// the chain rotates back to its start position. A new command is taken only in the idle
// state. Reset empties the queue; slot contents are not cleared. A stalled out_tready
// holds the sequencer in place in the status and list states.
`default_nettype none

module timed_message_queue #(
  parameter int SLOTS = 5
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // handle, show_time, fore, back, shade
  input  logic [1:0]   in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [167:0] out_tdata,  // accepted, fill, handle, y, x, z, fore, back, shade
  output logic [1:0]   out_tuser,  // result kind
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import tmq_pkg::*;

  localparam int CW = $clog2(SLOTS + 1);
  localparam int YW = 18 + $clog2(SLOTS);
  localparam logic signed [YW-1:0] Y_HI = YW'(32767);
  localparam logic signed [YW-1:0] Y_LO = YW'(-32768);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SORT = 6'b000010,
    S_CNT  = 6'b000100,
    S_STAT = 6'b001000,
    S_LIST = 6'b010000,
    S_ROT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        accepted;
    logic [2:0]  fill;
    logic [15:0] handle;
    logic [15:0] y;
    logic [15:0] x;
    logic [15:0] z;
    logic [31:0] fore;
    logic [31:0] back;
    logic [31:0] shade;
    logic        last;
  } result_t;

  logic [15:0] x_position, start_y, y_step, depth_z;

  state_t  state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic signed [YW-1:0] y_acc_r, y_nxt;
  logic    acc_r, acc_nxt;
  logic [1:0] kind_r, kind_nxt;
  result_t out_r, out_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    slot_free;
  logic    in_fire;
  logic [CW-1:0] cnt_enc;
  logic [CW-1:0] count_m1;
  logic [15:0] y_sat;

  cell_ctrl_t ctrl;
  entry_t     push_ent;
  entry_t     cell_q [SLOTS];
  logic [SLOTS-1:0] occ;
  logic [SLOTS:0]   alive_ext;

  tmq_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .x_position  (x_position),
    .start_y     (start_y),
    .y_step      (y_step),
    .depth_z     (depth_z)
  );

  assign push_ent = '{alive: 1'b1,
                      slot: '{handle: in_tdata[15:0],  ticks: in_tdata[31:16],
                              fore:   in_tdata[63:32], back:  in_tdata[95:64],
                              shade:  in_tdata[127:96]}};

  // Newest entry sits in cell 0; older ones move up the chain.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    localparam int UP = (i + 1 == SLOTS) ? 0 : i + 1;
    assign occ[i]       = (CW'(i) < count_r);
    assign alive_ext[i] = cell_q[i].alive;
    if (i == 0) begin : g_low
      tmq_cell #(.ODD(1'b0), .LOW_END(1'b1), .HIGH_END(SLOTS == 1)) u_cell (
        .clk (clk), .rst_n (rst_n), .ctrl (ctrl), .occ (occ[i]),
        .dn_in (push_ent), .up_in (cell_q[UP]), .q (cell_q[i])
      );
    end else begin : g_mid
      tmq_cell #(.ODD(bit'(i % 2)), .LOW_END(1'b0), .HIGH_END(i == SLOTS - 1)) u_cell (
        .clk (clk), .rst_n (rst_n), .ctrl (ctrl), .occ (occ[i]),
        .dn_in (cell_q[i-1]), .up_in (cell_q[UP]), .q (cell_q[i])
      );
    end
  end
  assign alive_ext[SLOTS] = 1'b0;

  // After compaction the live entries form a block at the bottom; find its top.
  always_comb begin
    cnt_enc = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (alive_ext[i] && !alive_ext[i+1]) begin
        cnt_enc = cnt_enc | CW'(i + 1);
      end
    end
  end

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign count_m1  = CW'(count_r - 1'b1);

  always_comb begin
    if (y_acc_r > Y_HI) begin
      y_sat = 16'h7fff;
    end else if (y_acc_r < Y_LO) begin
      y_sat = 16'h8000;
    end else begin
      y_sat = y_acc_r[15:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    y_nxt         = y_acc_r;
    acc_nxt       = acc_r;
    kind_nxt      = kind_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ctrl.op       = OP_HOLD;
    ctrl.phase    = k_r[0];
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          acc_nxt   = 1'b0;
          kind_nxt  = KIND_STATUS;
          state_nxt = S_STAT;
          case (in_tuser)
            CMD_ADD: begin
              if (count_r < CW'(SLOTS)) begin
                ctrl.op   = OP_PUSH;
                count_nxt = CW'(count_r + 1'b1);
                acc_nxt   = 1'b1;
              end
            end
            CMD_TICK: begin
              ctrl.op   = OP_MARK;
              k_nxt     = '0;
              state_nxt = S_SORT;
            end
            CMD_LIST: begin
              if (count_r == '0) begin
                kind_nxt = KIND_EMPTY;
              end else begin
                k_nxt     = '0;
                y_nxt     = {{(YW-16){start_y[15]}}, start_y};
                state_nxt = S_LIST;
              end
            end
            default: count_nxt = '0;
          endcase
        end
      end
      S_SORT: begin
        ctrl.op = OP_SORT;
        if (k_r == CW'(SLOTS - 1)) begin
          state_nxt = S_CNT;
        end else begin
          k_nxt = CW'(k_r + 1'b1);
        end
      end
      S_CNT: begin
        count_nxt = cnt_enc;
        state_nxt = S_STAT;
      end
      S_STAT: begin
        if (slot_free) begin
          out_nxt          = '0;
          out_nxt.kind     = kind_r;
          out_nxt.accepted = acc_r;
          out_nxt.fill     = 3'(count_r);
          out_nxt.last     = 1'b1;
          out_valid_nxt    = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_LIST: begin
        if (slot_free) begin
          out_nxt        = '0;
          out_nxt.kind   = KIND_ENTRY;
          out_nxt.fill   = 3'(count_r);
          out_nxt.handle = cell_q[0].slot.handle;
          out_nxt.y      = y_sat;
          out_nxt.x      = x_position;
          out_nxt.z      = depth_z;
          out_nxt.fore   = cell_q[0].slot.fore;
          out_nxt.back   = cell_q[0].slot.back;
          out_nxt.shade  = cell_q[0].slot.shade;
          out_nxt.last   = (k_r == count_m1);
          out_valid_nxt  = 1'b1;
          ctrl.op        = OP_ROTATE;
          y_nxt          = y_acc_r + {{(YW-16){y_step[15]}}, y_step};
          k_nxt          = CW'(k_r + 1'b1);
          if (k_r == count_m1) begin
            state_nxt = (k_r == CW'(SLOTS - 1)) ? S_IDLE : S_ROT;
          end
        end
      end
      S_ROT: begin
        // finish the lap so the oldest entry returns to its place
        ctrl.op = OP_ROTATE;
        k_nxt   = CW'(k_r + 1'b1);
        if (k_r == CW'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      acc_r       <= 1'b0;
      kind_r      <= KIND_STATUS;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      kind_r      <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    y_acc_r <= y_nxt;
    out_r   <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {4'd0, out_r.shade, out_r.back, out_r.fore, out_r.z, out_r.x,
                       out_r.y, out_r.handle, out_r.fill, out_r.accepted};

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(SLOTS))
    else $error("queue fill exceeds slot count");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == CMD_ADD && count_r < CW'(SLOTS))
      |=> count_r == CW'($past(count_r) + 1'b1))
    else $error("stored add did not raise the fill");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == CMD_CLEAR) |=> count_r == '0)
    else $error("clear left entries behind");

  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) |-> (k_r < count_r))
    else $error("list index ran past the held entries");

  a_tick_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CNT) |=> count_r <= $past(count_r))
    else $error("tick increased the fill");

endmodule

`default_nettype wire

@@ verif/timed_message_queue_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the timed message queue: directed and random commands under stalls.
module timed_message_queue_tb;
  import tmq_pkg::*;

  localparam int SLOTS = 5;
  // tick is the slowest command; leave a margin on top
  localparam int SETTLE_CYCLES = SLOTS + 8;

  typedef struct {
    logic [1:0]  kind;
    logic        accepted;
    logic [2:0]  fill;
    logic [15:0] handle;
    logic [15:0] y;
    logic [15:0] x;
    logic [15:0] z;
    logic [31:0] fore;
    logic [31:0] back;
    logic [31:0] shade;
    logic [3:0]  pad;
    logic        last;
  } report_t;

  function automatic report_t unpack_report(logic [1:0] kind, logic [167:0] d, logic last);
    report_t r;
    r.kind     = kind;
    r.accepted = d[0];
    r.fill     = d[3:1];
    r.handle   = d[19:4];
    r.y        = d[35:20];
    r.x        = d[51:36];
    r.z        = d[67:52];
    r.fore     = d[99:68];
    r.back     = d[131:100];
    r.shade    = d[163:132];
    r.pad      = d[167:164];
    r.last     = last;
    return r;
  endfunction

  class message_list_scoreboard;
    logic [15:0] x_pos;
    logic [15:0] top_y;
    logic [15:0] y_step;
    logic [15:0] depth;
    slot_t       slots[SLOTS];
    int          held;
    report_t     queued_reports[$];
    int          mismatches;

    function new();
      x_pos      = '0;
      top_y      = '0;
      y_step     = '0;
      depth      = '0;
      held       = 0;
      mismatches = 0;
    endfunction

    function void set_reg(int idx, logic [15:0] v);
      case (idx)
        REG_X_POS:   x_pos  = v;
        REG_START_Y: top_y  = v;
        REG_Y_STEP:  y_step = v;
        REG_DEPTH_Z: depth  = v;
        default: ;
      endcase
    endfunction

    function report_t status(logic acc);
      report_t r;
      r          = '{default: '0};
      r.kind     = KIND_STATUS;
      r.accepted = acc;
      r.fill     = held[2:0];
      r.last     = 1'b1;
      return r;
    endfunction

    // Advance the list by one accepted command and queue the results it causes.
    function void apply_command(logic [1:0] cmd, logic [127:0] d);
      report_t r;
      slot_t   s;
      int      kept;
      int      ypos;
      case (cmd)
        CMD_ADD: begin
          if (held >= SLOTS) begin
            queued_reports.push_back(status(1'b0));
          end else begin
            s.handle    = d[15:0];
            s.ticks     = d[31:16];
            s.fore      = d[63:32];
            s.back      = d[95:64];
            s.shade     = d[127:96];
            slots[held] = s;
            held++;
            queued_reports.push_back(status(1'b1));
          end
        end
        CMD_TICK: begin
          kept = 0;
          for (int i = 0; i < held; i++) begin
            s       = slots[i];
            s.ticks = s.ticks - 16'd1;
            if (s.ticks != 16'd0) begin
              slots[kept] = s;
              kept++;
            end
          end
          held = kept;
          queued_reports.push_back(status(1'b0));
        end
        CMD_CLEAR: begin
          held = 0;
          queued_reports.push_back(status(1'b0));
        end
        default: begin
          if (held == 0) begin
            r      = status(1'b0);
            r.kind = KIND_EMPTY;
            queued_reports.push_back(r);
          end else begin
            for (int k = 0; k < held; k++) begin
              s    = slots[held - 1 - k];
              ypos = int'($signed(top_y)) + k * int'($signed(y_step));
              if (ypos > 32767) ypos = 32767;
              if (ypos < -32768) ypos = -32768;
              r        = '{default: '0};
              r.kind   = KIND_ENTRY;
              r.fill   = held[2:0];
              r.handle = s.handle;
              r.y      = ypos[15:0];
              r.x      = x_pos;
              r.z      = depth;
              r.fore   = s.fore;
              r.back   = s.back;
              r.shade  = s.shade;
              r.last   = (k == held - 1);
              queued_reports.push_back(r);
            end
          end
        end
      endcase
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] %s", $time, msg);
    endfunction

    function void check_report(report_t got);
      report_t want;
      string   diff;
      if (queued_reports.size() == 0) begin
        note_failure($sformatf("result with nothing pending: %p", got));
        return;
      end
      want = queued_reports.pop_front();
      diff = "";
      if (got.kind !== want.kind)
        diff = {diff, $sformatf(" kind %0d/%0d", want.kind, got.kind)};
      if (got.accepted !== want.accepted)
        diff = {diff, $sformatf(" accepted %0b/%0b", want.accepted, got.accepted)};
      if (got.fill !== want.fill)
        diff = {diff, $sformatf(" fill %0d/%0d", want.fill, got.fill)};
      if (got.handle !== want.handle)
        diff = {diff, $sformatf(" handle %h/%h", want.handle, got.handle)};
      if (got.y !== want.y)
        diff = {diff, $sformatf(" y %h/%h", want.y, got.y)};
      if (got.x !== want.x)
        diff = {diff, $sformatf(" x %h/%h", want.x, got.x)};
      if (got.z !== want.z)
        diff = {diff, $sformatf(" z %h/%h", want.z, got.z)};
      if (got.fore !== want.fore)
        diff = {diff, $sformatf(" fore %h/%h", want.fore, got.fore)};
      if (got.back !== want.back)
        diff = {diff, $sformatf(" back %h/%h", want.back, got.back)};
      if (got.shade !== want.shade)
        diff = {diff, $sformatf(" shade %h/%h", want.shade, got.shade)};
      if (got.pad !== want.pad)
        diff = {diff, $sformatf(" pad %h/%h", want.pad, got.pad)};
      if (got.last !== want.last)
        diff = {diff, $sformatf(" last %0b/%0b", want.last, got.last)};
      if (diff != "") note_failure({"result mismatch (expected/actual):", diff});
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // handle, show_time, fore, back, shade
  logic [1:0]   in_tuser;   // command
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [167:0] out_tdata;  // accepted, fill, handle, y, x, z, fore, back, shade
  logic [1:0]   out_tuser;  // result kind
  logic         out_tlast;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [3:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  message_list_scoreboard sb = new();

  timed_message_queue #(.SLOTS(SLOTS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** timed_message_queue: FAILED **");
    $finish;
  end

  // Result side: random backpressure, check every accepted transaction.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
    if (rst_n && out_tvalid && out_tready)
      sb.check_report(unpack_report(out_tuser, out_tdata, out_tlast));
  end

  function automatic logic [127:0] pack_msg(logic [15:0] h, logic [15:0] t,
                                            logic [31:0] f, logic [31:0] b, logic [31:0] s);
    return {s, b, f, t, h};
  endfunction

  function automatic logic [127:0] random_msg();
    int          pick;
    logic [15:0] t;
    pick = $urandom_range(99);
    if (pick < 70)      t = 16'($urandom_range(1, 6));
    else if (pick < 80) t = 16'd0;
    else                t = 16'($urandom_range(0, 65535));
    return pack_msg(16'($urandom), t, $urandom, $urandom, $urandom);
  endfunction

  // Valid is left high after a transaction; a drain, or an idle gap in the next call, lowers it.
  task automatic send_cmd(logic [1:0] cmd, logic [127:0] d);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    sb.apply_command(cmd, d);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.queued_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(int idx, logic [15:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 4'(idx * 4);
    cfg_pwdata  <= {16'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    // hold the bus idle before the next transaction
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic set_view(logic [15:0] x, logic [15:0] y0, logic [15:0] step, logic [15:0] z);
    cfg_write(REG_X_POS, x);
    cfg_write(REG_START_Y, y0);
    cfg_write(REG_Y_STEP, step);
    cfg_write(REG_DEPTH_Z, z);
  endtask

  task automatic run_random(int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 42)      send_cmd(CMD_ADD, random_msg());
      else if (pick < 70) send_cmd(CMD_TICK, random_msg());
      else if (pick < 94) send_cmd(CMD_LIST, random_msg());
      else                send_cmd(CMD_CLEAR, random_msg());
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= CMD_ADD;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, fill to the limit, refusal, saturation both ways.
    rx_idle_pct = 40;
    send_cmd(CMD_LIST, '0);
    send_cmd(CMD_TICK, '1);
    send_cmd(CMD_CLEAR, '0);
    send_cmd(CMD_ADD, pack_msg(16'h0000, 16'd1, 32'h0, 32'h0, 32'h0));
    send_cmd(CMD_ADD, pack_msg(16'hFFFF, 16'hFFFF, '1, '1, '1));
    send_cmd(CMD_ADD, pack_msg(16'h5A5A, 16'd0, 32'h1234_5678, 32'h8765_4321, 32'hFF00_FF00));
    send_cmd(CMD_ADD, pack_msg(16'hA5A5, 16'd1, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000));
    send_cmd(CMD_ADD, pack_msg(16'h0001, 16'd2, 32'h0F0F_0F0F, 32'hF0F0_F0F0, '1));
    send_cmd(CMD_ADD, pack_msg(16'h8000, 16'd3, '1, '0, '1));
    send_cmd(CMD_LIST, '0);
    drain();
    set_view(16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_cmd(CMD_LIST, '1);
    send_cmd(CMD_TICK, '0);
    send_cmd(CMD_LIST, '0);
    drain();
    set_view(16'h7FFF, 16'h8000, 16'h8000, 16'h0000);
    send_cmd(CMD_ADD, pack_msg(16'h1111, 16'd1, 32'h1, 32'h2, 32'h3));
    send_cmd(CMD_ADD, pack_msg(16'h2222, 16'd4, 32'h4, 32'h5, 32'h6));
    send_cmd(CMD_LIST, '0);
    send_cmd(CMD_TICK, '0);
    send_cmd(CMD_LIST, '0);
    send_cmd(CMD_CLEAR, '1);
    send_cmd(CMD_LIST, '0);
    send_cmd(CMD_TICK, '0);
    drain();

    set_view(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    tx_idle_pct = 33;
    rx_idle_pct = 73;
    run_random(50);
    drain();

    set_view(16'($urandom), 16'($urandom_range(0, 400)), 16'($urandom_range(0, 80)) - 16'd40,
             16'($urandom));
    tx_idle_pct = 73;
    rx_idle_pct = 33;
    run_random(50);
    drain();

    set_view(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(50);
    drain();

    if (sb.mismatches == 0 && sb.queued_reports.size() == 0) begin
      $display("** timed_message_queue: PASSED **");
    end else begin
      $display("** timed_message_queue: FAILED **");
    end
    $finish;
  end

endmodule
